// File: hdl/assert_macros.svh
// Assertion macros for the RTL that checks itself.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// File: hdl/fvn_pkg.sv
// Types, codes and helpers for the fractal value noise block.
// Used by fvn_cubic and fractal_value_noise_cubic_top; depends on nothing.
package fvn_pkg;

    // Interpolation datapath width: holds every coefficient and Horner term.
    localparam int VW = 34;
    localparam int FW = 16;

    typedef logic signed [VW-1:0] t_val;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    localparam logic REG_OCTAVES = 1'b0;
    localparam logic REG_DIMS    = 1'b1;

    typedef struct packed {
        logic          start;
        logic [FW-1:0] frac;
        t_val          y0;
        t_val          y1;
        t_val          y2;
        t_val          y3;
    } t_cub_req;

    typedef struct packed {
        logic done;
        t_val value;
    } t_cub_rsp;

    // Absolute value of a Q16.16 coordinate; the most negative value saturates.
    function automatic logic [31:0] abs_coord(logic [31:0] x);
        logic [31:0] r;
        if (x == 32'h8000_0000) begin
            r = 32'h7FFF_FFFF;
        end else if (x[31]) begin
            r = (~x) + 32'd1;
        end else begin
            r = x;
        end
        return r;
    endfunction

endpackage

// File: hdl/fvn_cubic.sv
// Iterative cubic interpolator: one shared multiplier, Horner over three passes.
// Depends on fvn_pkg for the value type and the request/response structs.
module fvn_cubic (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fvn_pkg::t_cub_req i_req,
    output fvn_pkg::t_cub_rsp o_rsp
);

    localparam int PW = fvn_pkg::VW + fvn_pkg::FW + 1;

    typedef enum logic [1:0] {E_IDLE, E_MUL, E_ADD} t_estate;

    t_estate                  r_state;
    logic [1:0]               r_step;
    logic [fvn_pkg::FW-1:0]   r_t;
    fvn_pkg::t_val            r_h, r_a1, r_a2, r_a3;
    logic signed [PW-1:0]     r_p;
    logic                     r_done;

    fvn_pkg::t_val w_a0, w_a1, w_coef, w_rnd;
    logic signed [PW-1:0] w_rsum;

    assign w_a0 = i_req.y3 - i_req.y2 - i_req.y0 + i_req.y1;
    assign w_a1 = i_req.y0 - i_req.y1 - w_a0;

    always_comb begin
        case (r_step)
            2'd0:    w_coef = r_a1;
            2'd1:    w_coef = r_a2;
            default: w_coef = r_a3;
        endcase
    end

    // Round to nearest at bit 16, ties upward.
    assign w_rsum = r_p + PW'(32768);
    assign w_rnd  = fvn_pkg::t_val'(w_rsum >>> 16) + w_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_step  <= 2'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                E_IDLE: begin
                    if (i_req.start) begin
                        r_h     <= w_a0;
                        r_a1    <= w_a1;
                        r_a2    <= i_req.y2 - i_req.y0;
                        r_a3    <= i_req.y1;
                        r_t     <= i_req.frac;
                        r_step  <= 2'd0;
                        r_state <= E_MUL;
                    end
                end
                E_MUL: begin
                    r_p     <= PW'(r_h) * PW'($signed({1'b0, r_t}));
                    r_state <= E_ADD;
                end
                E_ADD: begin
                    r_h <= w_rnd;
                    if (r_step == 2'd2) begin
                        r_done  <= 1'b1;
                        r_state <= E_IDLE;
                    end else begin
                        r_step  <= r_step + 2'd1;
                        r_state <= E_MUL;
                    end
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_h;

endmodule

// File: hdl/fractal_value_noise_cubic_top.sv
// Fractal value noise top level: table memory, address sequencer, octave sum.
// Depends on fvn_pkg, fvn_cubic and assert_macros.svh.
//
// A load request writes one table entry. An evaluate request runs, per octave,
// a row cubic on each group of four entries read from the single table port,
// a plane cubic over each four rows in 2D and 3D, a volume cubic over the four
// planes in 3D, and then adds the weighted octave to the sum. The input is not
// ready while an evaluate is in work. The table must be loaded before it is
// read; TABLE_DEPTH is a power of two.
module fractal_value_noise_cubic_top #(
    parameter int TABLE_DEPTH = 65536,
    parameter int MAX_OCTAVES = 16,
    parameter int ROW_SHIFT   = 4,
    parameter int PLANE_SHIFT = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // table_address[15:0], table_value[31:16], coord_x[63:32],
    // coord_y[95:64], coord_z[127:96]
    input  logic [127:0] s_axis_tdata,
    // action[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // noise_value[31:0]
    output logic [31:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [0:0]   i_cfg_index,
    input  logic [4:0]   i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int KW = $clog2(MAX_OCTAVES + 1);
    localparam int VW = fvn_pkg::VW;
    localparam int FW = fvn_pkg::FW;
    localparam logic signed [VW:0] SUM_MAX = (VW+1)'(33'sh0_7FFF_FFFF);
    localparam logic signed [VW:0] SUM_MIN = -SUM_MAX - (VW+1)'(1);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_WAITX, S_CSTART, S_CWAIT, S_OCT, S_DONE
    } t_state;

    t_state r_state;

    logic [4:0]    r_cfg_oct;
    logic [1:0]    r_cfg_dims;
    logic [1:0]    r_dims;
    logic [KW-1:0] r_oct, r_k;
    logic [AW-1:0] r_ix, r_iy, r_iz;
    logic [FW-1:0] r_fx, r_fy, r_fz;
    logic [1:0]    r_col, r_row, r_pln, r_lvl, r_cap_idx;
    logic          r_cap_vld;
    logic signed [16:0] r_xbuf [4];
    fvn_pkg::t_val r_ybuf [4];
    fvn_pkg::t_val r_zbuf [4];
    fvn_pkg::t_val r_v;
    logic signed [VW:0] r_sum;
    logic          r_out_vld;
    logic [31:0]   r_out_data;

    logic [15:0]   r_mem [TABLE_DEPTH];
    logic [15:0]   r_rdata;

    logic [31:0]   w_ax, w_ay, w_az;
    logic          w_in_acc, w_wr_en;
    logic [AW-1:0] w_rd_addr;
    fvn_pkg::t_cub_req w_req;
    fvn_pkg::t_cub_rsp w_rsp;
    logic signed [VW:0] w_vext, w_term;
    logic [31:0]   w_sat;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_wr_en  = w_in_acc && (s_axis_tuser[0] == fvn_pkg::ACT_LOAD);
    assign w_ax     = fvn_pkg::abs_coord(s_axis_tdata[63:32]);
    assign w_ay     = fvn_pkg::abs_coord(s_axis_tdata[95:64]);
    assign w_az     = fvn_pkg::abs_coord(s_axis_tdata[127:96]);

    // Entry address: base plus plane, row and column offsets, wrapped to depth.
    assign w_rd_addr = r_ix + (r_iy << ROW_SHIFT) + (r_iz << PLANE_SHIFT)
                     + (AW'(r_pln) << PLANE_SHIFT) + (AW'(r_row) << ROW_SHIFT)
                     + AW'(r_col);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[s_axis_tdata[AW-1:0]] <= s_axis_tdata[31:16];
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    always_comb begin
        w_req.start = (r_state == S_CSTART);
        case (r_lvl)
            2'd0: begin
                w_req.frac = r_fx;
                w_req.y0 = VW'(r_xbuf[0]);
                w_req.y1 = VW'(r_xbuf[1]);
                w_req.y2 = VW'(r_xbuf[2]);
                w_req.y3 = VW'(r_xbuf[3]);
            end
            2'd1: begin
                w_req.frac = r_fy;
                w_req.y0 = r_ybuf[0];
                w_req.y1 = r_ybuf[1];
                w_req.y2 = r_ybuf[2];
                w_req.y3 = r_ybuf[3];
            end
            default: begin
                w_req.frac = r_fz;
                w_req.y0 = r_zbuf[0];
                w_req.y1 = r_zbuf[1];
                w_req.y2 = r_zbuf[2];
                w_req.y3 = r_zbuf[3];
            end
        endcase
    end

    fvn_cubic u_cubic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Octave k weighs 2^-(k+1), rounded to nearest with ties upward.
    assign w_vext = {r_v[VW-1], r_v} + ((VW+1)'(1) << r_k);
    assign w_term = w_vext >>> ({1'b0, r_k} + (KW+1)'(1));

    always_comb begin
        if (r_sum > SUM_MAX) begin
            w_sat = SUM_MAX[31:0];
        end else if (r_sum < SUM_MIN) begin
            w_sat = SUM_MIN[31:0];
        end else begin
            w_sat = r_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cap_vld) begin
            r_xbuf[r_cap_idx] <= $signed({r_rdata, 1'b0});
        end
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cfg_oct  <= 5'd4;
            r_cfg_dims <= 2'd3;
            r_out_vld  <= 1'b0;
            r_cap_vld  <= 1'b0;
            r_col      <= 2'd0;
            r_row      <= 2'd0;
            r_pln      <= 2'd0;
            r_lvl      <= 2'd0;
            r_k        <= '0;
        end else begin
            r_cap_vld <= (r_state == S_READ);
            r_cap_idx <= r_col;
            if (i_cfg_valid) begin
                if (i_cfg_index[0] == fvn_pkg::REG_OCTAVES) begin
                    r_cfg_oct <= i_cfg_data;
                end else begin
                    r_cfg_dims <= i_cfg_data[1:0];
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && s_axis_tuser[0] == fvn_pkg::ACT_EVAL) begin
                        r_dims <= (r_cfg_dims == 2'd0) ? 2'd1 : r_cfg_dims;
                        r_oct  <= (r_cfg_oct > 5'(MAX_OCTAVES)) ? KW'(MAX_OCTAVES)
                                                                : KW'(r_cfg_oct);
                        r_ix   <= w_ax[16 +: AW];
                        r_fx   <= w_ax[FW-1:0];
                        r_iy   <= (r_cfg_dims >= 2'd2) ? w_ay[16 +: AW] : '0;
                        r_fy   <= (r_cfg_dims >= 2'd2) ? w_ay[FW-1:0] : '0;
                        r_iz   <= (r_cfg_dims == 2'd3) ? w_az[16 +: AW] : '0;
                        r_fz   <= (r_cfg_dims == 2'd3) ? w_az[FW-1:0] : '0;
                        r_sum  <= '0;
                        r_k    <= '0;
                        r_col  <= 2'd0;
                        r_row  <= 2'd0;
                        r_pln  <= 2'd0;
                        r_lvl  <= 2'd0;
                        r_state <= (r_cfg_oct == 5'd0) ? S_DONE : S_READ;
                    end
                end
                S_READ: begin
                    r_col <= r_col + 2'd1;
                    if (r_col == 2'd3) begin
                        r_state <= S_WAITX;
                    end
                end
                S_WAITX:  r_state <= S_CSTART;
                S_CSTART: r_state <= S_CWAIT;
                S_CWAIT: begin
                    if (w_rsp.done) begin
                        r_v <= w_rsp.value;
                        if (r_lvl == 2'd0) begin
                            r_ybuf[r_row] <= w_rsp.value;
                            if (r_dims == 2'd1) begin
                                r_state <= S_OCT;
                            end else if (r_row == 2'd3) begin
                                r_row   <= 2'd0;
                                r_lvl   <= 2'd1;
                                r_state <= S_CSTART;
                            end else begin
                                r_row   <= r_row + 2'd1;
                                r_state <= S_READ;
                            end
                        end else if (r_lvl == 2'd1) begin
                            r_zbuf[r_pln] <= w_rsp.value;
                            if (r_dims == 2'd2) begin
                                r_state <= S_OCT;
                            end else if (r_pln == 2'd3) begin
                                r_pln   <= 2'd0;
                                r_lvl   <= 2'd2;
                                r_state <= S_CSTART;
                            end else begin
                                r_pln   <= r_pln + 2'd1;
                                r_lvl   <= 2'd0;
                                r_state <= S_READ;
                            end
                        end else begin
                            r_state <= S_OCT;
                        end
                    end
                end
                S_OCT: begin
                    // Add the weighted octave, then double every coordinate.
                    r_sum <= r_sum + w_term;
                    r_ix  <= {r_ix[AW-2:0], r_fx[FW-1]};
                    r_iy  <= {r_iy[AW-2:0], r_fy[FW-1]};
                    r_iz  <= {r_iz[AW-2:0], r_fz[FW-1]};
                    r_fx  <= {r_fx[FW-2:0], 1'b0};
                    r_fy  <= {r_fy[FW-2:0], 1'b0};
                    r_fz  <= {r_fz[FW-2:0], 1'b0};
                    r_k   <= r_k + KW'(1);
                    r_col <= 2'd0;
                    r_row <= 2'd0;
                    r_pln <= 2'd0;
                    r_lvl <= 2'd0;
                    r_state <= (r_k + KW'(1) == r_oct) ? S_DONE : S_READ;
                end
                S_DONE: begin
                    // Hold until the previous result has left.
                    if (!r_out_vld) begin
                        r_out_vld  <= 1'b1;
                        r_out_data <= w_sat;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "assert_macros.svh"

    `ASSERT_CLK(a_done_in_wait, w_rsp.done |-> (r_state == S_CWAIT), "cubic done outside wait")
    `ASSERT_CLK(a_out_from_done, $rose(m_axis_tvalid) |-> $past(r_state == S_DONE), "stray result")
    `ASSERT_NEVER(a_oct_range, (r_state == S_READ) && (r_k >= r_oct), "octave index out of range")

endmodule

// File: verif/fvn_noise_checker.sv
// Checker for the fractal value noise block: watches the load/evaluate stream,
// the result stream and the register channel, predicts each noise value and
// compares it. Depends on fvn_pkg for the action and register codes.
module fvn_noise_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_valid,
    input  logic         i_s_ready,
    input  logic [127:0] i_s_data,
    input  logic [0:0]   i_s_user,
    input  logic         i_m_valid,
    input  logic         i_m_ready,
    input  logic [31:0]  i_m_data,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [0:0]   i_cfg_index,
    input  logic [4:0]   i_cfg_data,
    output int           o_errors,
    output int           o_pending,
    output int           o_checked
);

    localparam int DEPTH       = 65536;
    localparam int OCT_MAX     = 16;
    localparam int ROW_SH      = 4;
    localparam int PLANE_SH    = 8;

    logic [15:0] noise_tbl [0:DEPTH-1];
    logic [4:0]  octaves;
    logic [1:0]  dims;
    logic [31:0] noise_q [$];

    // Table entry as Q.16 (Q1.15 times two).
    function automatic longint tbl_val(logic [31:0] a);
        return longint'($signed(noise_tbl[a[15:0]])) * 2;
    endfunction

    function automatic longint rnd16(longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic longint cubic_interp(longint y0, longint y1, longint y2,
                                            longint y3, longint t);
        longint c0, c1, c2, h;
        c0 = y3 - y2 - y0 + y1;
        c1 = y0 - y1 - c0;
        c2 = y2 - y0;
        h = rnd16(c0 * t) + c1;
        h = rnd16(h * t) + c2;
        return rnd16(h * t) + y1;
    endfunction

    function automatic longint row_at(logic [31:0] a, longint tx);
        return cubic_interp(tbl_val(a), tbl_val(a + 32'd1), tbl_val(a + 32'd2),
                            tbl_val(a + 32'd3), tx);
    endfunction

    function automatic longint plane_at(logic [31:0] a, longint tx, longint ty);
        longint r [4];
        for (int i = 0; i < 4; i++) begin
            r[i] = row_at(a + (32'(i) << ROW_SH), tx);
        end
        return cubic_interp(r[0], r[1], r[2], r[3], ty);
    endfunction

    function automatic logic [31:0] mag(logic [31:0] c);
        if (c == 32'h8000_0000) return 32'h7FFF_FFFF;
        return c[31] ? (~c + 32'd1) : c;
    endfunction

    function automatic logic [31:0] noise_at(logic [31:0] cx, logic [31:0] cy,
                                             logic [31:0] cz);
        int          nd, no;
        logic [31:0] ax, ay, az, ix, iy, iz, base;
        logic [15:0] fx, fy, fz;
        longint      v, sum;
        longint      p [4];
        nd = (dims == 2'd0) ? 1 : int'(dims);
        no = (octaves > OCT_MAX) ? OCT_MAX : int'(octaves);
        ax = mag(cx);
        ay = (nd >= 2) ? mag(cy) : 32'd0;
        az = (nd >= 3) ? mag(cz) : 32'd0;
        ix = {16'd0, ax[31:16]}; fx = ax[15:0];
        iy = {16'd0, ay[31:16]}; fy = ay[15:0];
        iz = {16'd0, az[31:16]}; fz = az[15:0];
        sum = 0;
        for (int k = 0; k < no; k++) begin
            base = ix + (iy << ROW_SH) + (iz << PLANE_SH);
            if (nd == 1) begin
                v = row_at(base, longint'(fx));
            end else if (nd == 2) begin
                v = plane_at(base, longint'(fx), longint'(fy));
            end else begin
                for (int i = 0; i < 4; i++) begin
                    p[i] = plane_at(base + (32'(i) << PLANE_SH), longint'(fx),
                                    longint'(fy));
                end
                v = cubic_interp(p[0], p[1], p[2], p[3], longint'(fz));
            end
            sum += (v + (64'sd1 <<< k)) >>> (k + 1);
            // Double the coordinates: fraction MSB carries into the integer.
            ix = {ix[30:0], fx[15]}; fx = {fx[14:0], 1'b0};
            iy = {iy[30:0], fy[15]}; fy = {fy[14:0], 1'b0};
            iz = {iz[30:0], fz[15]}; fz = {fz[14:0], 1'b0};
        end
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        return sum[31:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            octaves   <= 5'd4;
            dims      <= 2'd3;
            noise_q.delete();
            o_errors  <= 0;
            o_pending <= 0;
            o_checked <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == fvn_pkg::REG_OCTAVES) octaves <= i_cfg_data;
                else dims <= i_cfg_data[1:0];
            end
            if (i_m_valid && i_m_ready) begin
                if (noise_q.size() == 0) begin
                    $error("noise_value: unexpected result %h", i_m_data);
                    o_errors <= o_errors + 1;
                end else begin
                    if (noise_q[0] !== i_m_data) begin
                        $error("noise_value: expected %h actual %h", noise_q[0],
                               i_m_data);
                        o_errors <= o_errors + 1;
                    end
                    void'(noise_q.pop_front());
                    o_checked <= o_checked + 1;
                end
            end
            if (i_s_valid && i_s_ready) begin
                if (i_s_user[0] == fvn_pkg::ACT_LOAD) begin
                    noise_tbl[i_s_data[15:0]] = i_s_data[31:16];
                end else begin
                    noise_q.push_back(noise_at(i_s_data[63:32], i_s_data[95:64],
                                               i_s_data[127:96]));
                end
            end
            o_pending <= noise_q.size();
        end
    end

endmodule

// File: verif/fractal_value_noise_cubic_top_tb.sv
// Testbench top for fractal_value_noise_cubic_top: fills the table, runs
// directed and random evaluate phases over register settings, gives the verdict.
// Depends on fvn_pkg, the block and fvn_noise_checker.
module fractal_value_noise_cubic_top_tb;

    localparam int IDLE_LIMIT = 60000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [0:0]   i_cfg_index;
    logic [4:0]   i_cfg_data;

    int errors, pending, checked;
    int burst_left, max_gap, stall_pct, idle_cycles, evals_sent;

    fractal_value_noise_cubic_top uut (.*);

    fvn_noise_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_axis_tvalid), .i_s_ready(s_axis_tready),
        .i_s_data(s_axis_tdata), .i_s_user(s_axis_tuser),
        .i_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready),
        .i_m_data(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push(input logic act, input logic [15:0] addr, input logic [15:0] val,
                        input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {z, y, x, val, addr};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        if (act == fvn_pkg::ACT_EVAL) evals_sent++;
    endtask

    task automatic evaluate(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
        push(fvn_pkg::ACT_EVAL, 16'($urandom()), 16'($urandom()), x, y, z);
    endtask

    // Hold the stream until every pending result is back, then let loads settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [4:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                       16'($urandom())};
            3: return {16'($urandom()), 16'h8000};
            default: return $urandom();
        endcase
    endfunction

    int          ph_oct [8] = '{4, 16, 0, 1, 16, 31, 2, 7};
    int          ph_dim [8] = '{3, 1, 2, 3, 3, 0, 2, 2};
    int          ph_num [8] = '{150, 200, 60, 150, 30, 150, 150, 160};

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = fvn_pkg::ACT_LOAD;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = fvn_pkg::REG_OCTAVES;
        i_cfg_data    = '0;
        burst_left    = 0;
        max_gap       = 3;
        stall_pct     = 0;
        evals_sent    = 0;
        idle_cycles   = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole table so that no evaluate reads an unwritten entry.
        for (int a = 0; a < 65536; a++) begin
            push(fvn_pkg::ACT_LOAD, 16'(a),
                 (a == 0) ? 16'h7FFF : (a == 1) ? 16'h8000 : 16'($urandom()),
                 $urandom(), $urandom(), $urandom());
        end

        // Directed, reset settings first: extremes, half fraction, table wrap.
        evaluate(32'h0, 32'h0, 32'h0);
        evaluate(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        evaluate(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        evaluate(32'hFFFF_FFFF, 32'h0001_8000, 32'hFFFE_8000);
        evaluate(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        evaluate(32'hFFFF_0000, 32'h0FFF_0000, 32'h00FF_0000);
        push(fvn_pkg::ACT_LOAD, 16'hFFFF, 16'h8000, 32'h0, 32'h0, 32'h0);
        push(fvn_pkg::ACT_LOAD, 16'h0002, 16'h7FFF, 32'h0, 32'h0, 32'h0);
        evaluate(32'h7FFF_FFFF, 32'h1234_5678, 32'h8000_0001);
        drain();
        write_reg(fvn_pkg::REG_OCTAVES, 5'd16);
        write_reg(fvn_pkg::REG_DIMS, 5'd1);
        evaluate(32'h0000_8000, 32'hDEAD_BEEF, 32'hCAFE_F00D);
        evaluate(32'h8000_0000, 32'h0, 32'h0);
        drain();
        write_reg(fvn_pkg::REG_OCTAVES, 5'd0);
        evaluate(32'h1234_5678, 32'h8765_4321, 32'h0);
        drain();
        write_reg(fvn_pkg::REG_OCTAVES, 5'd31);
        write_reg(fvn_pkg::REG_DIMS, 5'd0);
        evaluate(32'hFFFF_8000, 32'h5555_5555, 32'hAAAA_AAAA);
        drain();
        write_reg(fvn_pkg::REG_OCTAVES, 5'd3);
        write_reg(fvn_pkg::REG_DIMS, 5'd2);
        evaluate(32'h8000_0000, 32'h7FFF_FFFF, 32'h1111_1111);
        evaluate(32'h0000_FFFF, 32'hFFFF_0001, 32'h0);

        // Random phases, one register setting each, an even random mix of loads and evaluates.
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            write_reg(fvn_pkg::REG_OCTAVES, 5'(ph_oct[ph]));
            write_reg(fvn_pkg::REG_DIMS, 5'(ph_dim[ph]));
            max_gap   = (ph % 3 == 0) ? 0 : $urandom_range(2, 12);
            stall_pct = (ph % 4 == 1) ? 0 : $urandom_range(10, 80);
            for (int n = 0; n < ph_num[ph]; n++) begin
                if ($urandom_range(0, 1)) begin
                    push(fvn_pkg::ACT_LOAD, 16'($urandom()), 16'($urandom()), $urandom(),
                         $urandom(), $urandom());
                end else begin
                    evaluate(rand_coord(), rand_coord(), rand_coord());
                end
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        $display("Covered full table fill, %0d evaluates over 1D/2D/3D and 0..31 octaves,",
                 evals_sent);
        $display("with %0d noise results compared under input gaps and output stalls.",
                 checked);
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
